// File: rtl/core/salc_pkg.sv
package salc_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_WIDTH   = 64;

  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int STAMP_W     = 32;
  localparam int TOTAL_W     = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] RST_SET_BITS   = 3'd4;
  localparam logic [3:0] RST_WAYS       = 4'd1;
  localparam logic [3:0] RST_BLOCK_BITS = 4'd4;

  // op code of a plain load or store
  localparam logic OP_ACCESS = 1'b0;
  // op code of a modify access ('M'), which scores a second hit
  localparam logic OP_MODIFY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_WAYS       = 2'd1,
    REG_BLOCK_BITS = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_EVICT
  } back_state_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic               miss;
    logic               eviction;
    logic               modify_hit;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] eviction_total;
  } result_t;

endpackage

// File: rtl/core/salc_queue.sv
module salc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);
  import salc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/salc_front.sv
module salc_front #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH,
  parameter int ENT_W        = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           op,
  input  logic [ADDR_WIDTH-1:0]          address,
  input  logic                           wr_en,
  input  logic [salc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [salc_pkg::CFG_W-1:0]     wr_data,
  input  logic                           clearing,
  input  logic                           q_full,
  output logic                           busy,
  output logic                           q_push,
  output logic [ENT_W-1:0]               q_data
);
  import salc_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);

  logic [2:0]            set_bits;
  logic [3:0]            ways;
  logic [3:0]            block_bits;
  logic [4:0]            sb;
  logic [5:0]            shift;
  logic [CNT_W-1:0]      nw;
  logic [ADDR_WIDTH-1:0] set_mask;
  logic [ADDR_WIDTH-1:0] set_full;
  logic [SET_W-1:0]      set_idx;
  logic [ADDR_WIDTH-1:0] tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= RST_SET_BITS;
      ways       <= RST_WAYS;
      block_bits <= RST_BLOCK_BITS;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_SET_BITS:   set_bits   <= wr_data[2:0];
        REG_WAYS:       ways       <= wr_data;
        REG_BLOCK_BITS: block_bits <= wr_data;
        default: ;
      endcase
    end
  end

  // saturate the geometry to what the arrays hold
  always_comb begin
    sb = (int'(set_bits) > MAX_SET_BITS) ? 5'(MAX_SET_BITS) : {2'b00, set_bits};
    if (ways == 4'd0) begin
      nw = CNT_W'(1);
    end else if (int'(ways) > MAX_WAYS) begin
      nw = CNT_W'(MAX_WAYS);
    end else begin
      nw = CNT_W'(ways);
    end
    shift    = {2'b00, block_bits} + {1'b0, sb};
    set_mask = (ADDR_WIDTH'(1) << sb) - ADDR_WIDTH'(1);
    set_full = (address >> block_bits) & set_mask;
    set_idx  = set_full[SET_W-1:0];
    tag      = address >> shift;
  end

  assign busy   = q_full | clearing;
  assign q_push = start & ~busy;
  assign q_data = {op, nw, set_idx, tag};

endmodule

// File: rtl/core/salc_back.sv
module salc_back #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH,
  parameter int ENT_W        = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  logic [ENT_W-1:0]   q_dout,
  output logic               q_pop,
  output logic               clearing,
  output salc_pkg::result_t  result
);
  import salc_pkg::*;

  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);

  logic [MAX_WAYS-1:0]                   valid_mem [NSETS];
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]   tag_mem   [NSETS];
  logic [MAX_WAYS-1:0][STAMP_W-1:0]      stamp_mem [NSETS];

  logic [MAX_WAYS-1:0]                   rd_valid;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]   rd_tag;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]      rd_stamp;

  logic [MAX_WAYS-1:0]                   valid_wdata;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]   tag_wdata;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]      stamp_wdata;
  logic [SET_W-1:0]                      wr_addr;
  logic                                  valid_we;
  logic                                  row_we;

  logic                  h_op;
  logic [CNT_W-1:0]      h_nw;
  logic [SET_W-1:0]      h_set;
  logic [ADDR_WIDTH-1:0] h_tag;

  logic                  cur_op;
  logic [CNT_W-1:0]      cur_nw;
  logic [SET_W-1:0]      cur_set;
  logic [ADDR_WIDTH-1:0] cur_tag;

  back_state_t           state;
  back_state_t           state_next;
  logic [SET_W-1:0]      clr_idx;

  logic [MAX_WAYS-1:0]   hit_vec;
  logic [MAX_WAYS-1:0]   free_vec;
  logic                  hit_any;
  logic                  free_any;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      free_way;
  logic [WAY_W-1:0]      tgt;
  logic [WAY_W-1:0]      scan_idx;
  logic [WAY_W-1:0]      best_way;
  logic [STAMP_W-1:0]    best_stamp;
  logic                  scan_last;
  logic                  finish;
  logic                  res_hit;
  logic                  res_evict;

  logic [STAMP_W-1:0]    access_clock;
  logic [STAMP_W-1:0]    stamp_new;
  logic [TOTAL_W-1:0]    hit_cnt;
  logic [TOTAL_W-1:0]    miss_cnt;
  logic [TOTAL_W-1:0]    evict_cnt;

  assign h_op  = q_dout[ENT_W-1];
  assign h_nw  = q_dout[ENT_W-2 -: CNT_W];
  assign h_set = q_dout[ADDR_WIDTH +: SET_W];
  assign h_tag = q_dout[ADDR_WIDTH-1:0];

  assign clearing  = (state == ST_CLEAR);
  assign stamp_new = access_clock + STAMP_W'(1);
  assign scan_last = (CNT_W'(scan_idx) == cur_nw - CNT_W'(1));

  // compare all ways of the set at once
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w]  = (CNT_W'(w) < cur_nw) && rd_valid[w] && (rd_tag[w] == cur_tag);
      free_vec[w] = (CNT_W'(w) < cur_nw) && !rd_valid[w];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    valid_we   = 1'b0;
    row_we     = 1'b0;
    finish     = 1'b0;
    res_hit    = 1'b0;
    res_evict  = 1'b0;
    tgt        = hit_any ? hit_way : free_way;
    unique case (state)
      ST_CLEAR: begin
        valid_we = 1'b1;
        if (clr_idx == SET_W'(NSETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (hit_any || free_any) begin
          valid_we   = 1'b1;
          row_we     = 1'b1;
          finish     = 1'b1;
          res_hit    = hit_any;
          state_next = ST_IDLE;
        end else if (cur_nw == CNT_W'(1)) begin
          state_next = ST_EVICT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_EVICT;
        end
      end
      ST_EVICT: begin
        tgt        = best_way;
        valid_we   = 1'b1;
        row_we     = 1'b1;
        finish     = 1'b1;
        res_evict  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_addr     = clearing ? clr_idx : cur_set;
    valid_wdata = rd_valid;
    tag_wdata   = rd_tag;
    stamp_wdata = rd_stamp;
    valid_wdata[tgt] = 1'b1;
    tag_wdata[tgt]   = cur_tag;
    stamp_wdata[tgt] = stamp_new;
    if (clearing) begin
      valid_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_we) begin
      valid_mem[wr_addr] <= valid_wdata;
    end
    if (row_we) begin
      tag_mem[wr_addr]   <= tag_wdata;
      stamp_mem[wr_addr] <= stamp_wdata;
    end
    if (q_pop) begin
      rd_valid <= valid_mem[h_set];
      rd_tag   <= tag_mem[h_set];
      rd_stamp <= stamp_mem[h_set];
    end
  end

  // request and LRU scan registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_op  <= h_op;
      cur_nw  <= h_nw;
      cur_set <= h_set;
      cur_tag <= h_tag;
    end
    if (state == ST_LOOK) begin
      best_way   <= '0;
      best_stamp <= rd_stamp[0];
      scan_idx   <= WAY_W'(1);
    end else if (state == ST_SCAN) begin
      if (rd_stamp[scan_idx] < best_stamp) begin
        best_way   <= scan_idx;
        best_stamp <= rd_stamp[scan_idx];
      end
      scan_idx <= scan_idx + WAY_W'(1);
    end
  end

  // result payload, held for the one cycle of the strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx             <= '0;
      access_clock        <= '0;
      hit_cnt             <= '0;
      miss_cnt            <= '0;
      evict_cnt           <= '0;
      result.done         <= 1'b0;
    end else begin
      result.done <= finish;
      if (clearing) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
      if (finish) begin
        access_clock <= stamp_new;
        hit_cnt      <= hit_cnt + TOTAL_W'(res_hit) + TOTAL_W'(cur_op == OP_MODIFY);
        miss_cnt     <= miss_cnt + TOTAL_W'(!res_hit);
        evict_cnt    <= evict_cnt + TOTAL_W'(res_evict);
        result.hit            <= res_hit;
        result.miss           <= !res_hit;
        result.eviction       <= res_evict;
        result.modify_hit     <= (cur_op == OP_MODIFY);
        result.hit_total      <= hit_cnt + TOTAL_W'(res_hit) + TOTAL_W'(cur_op == OP_MODIFY);
        result.miss_total     <= miss_cnt + TOTAL_W'(!res_hit);
        result.eviction_total <= evict_cnt + TOTAL_W'(res_evict);
      end
    end
  end

endmodule

// File: rtl/core/set_assoc_lru_cache_tags_core.sv
// Tag array of a set-associative cache with LRU replacement. Pulse start with op and address
// while busy is low; requests wait in a two-entry queue. Each request yields one result,
// shown on hit/miss/eviction/modify_hit and the running totals for the single cycle in which
// done is high; the receiver cannot stall, so capture it then. A hit or a fill of a free
// way goes through the tag pipeline's set read, then its compare and write back; an
// eviction adds a scan of the set's stamps, one way per cycle, before the victim is written.
// After reset the pipeline clears the valid bits of every set, one set per cycle, with busy
// held high; configuration writes are taken during that time.
module set_assoc_lru_cache_tags_core #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [ADDR_WIDTH-1:0]          address,
  input  logic                           wr_en,
  input  logic [salc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [salc_pkg::CFG_W-1:0]     wr_data,
  output logic                           done,
  output logic                           hit,
  output logic                           miss,
  output logic                           eviction,
  output logic                           modify_hit,
  output logic [salc_pkg::TOTAL_W-1:0]   hit_total,
  output logic [salc_pkg::TOTAL_W-1:0]   miss_total,
  output logic [salc_pkg::TOTAL_W-1:0]   eviction_total
);
  import salc_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int ENT_W = 1 + CNT_W + SET_W + ADDR_WIDTH;

  logic             clearing;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic [ENT_W-1:0] q_din;
  logic [ENT_W-1:0] q_dout;
  result_t          result;

  salc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .ENT_W        (ENT_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .address  (address),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .clearing (clearing),
    .q_full   (q_full),
    .busy     (busy),
    .q_push   (q_push),
    .q_data   (q_din)
  );

  salc_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  salc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .ENT_W        (ENT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_dout   (q_dout),
    .q_pop    (q_pop),
    .clearing (clearing),
    .result   (result)
  );

  assign done           = result.done;
  assign hit            = result.hit;
  assign miss           = result.miss;
  assign eviction       = result.eviction;
  assign modify_hit     = result.modify_hit;
  assign hit_total      = result.hit_total;
  assign miss_total     = result.miss_total;
  assign eviction_total = result.eviction_total;

endmodule

// File: verif/testbench.sv
module testbench;
  import salc_pkg::*;

  localparam int NUM_LINES     = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
  localparam int SETTLE_CYCLES = 2 * DEF_MAX_WAYS + 8;
  localparam int MAX_ERR_LINES = 100;
  localparam int RESET_CYCLES  = 12;
  localparam int PHASE_ITEMS   = 250;
  localparam int NUM_PHASES    = 8;

  typedef enum logic [1:0] {
    RQ_ACCESS,
    RQ_WRITE,
    RQ_SETTLE
  } rq_kind_t;

  typedef struct packed {
    rq_kind_t                  kind;
    logic                      op;
    logic [DEF_ADDR_WIDTH-1:0] addr;
    cfg_reg_t                  reg_sel;
    logic [CFG_W-1:0]          value;
    int                        idle_pct;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic               miss;
    logic               eviction;
    logic               modify_hit;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evicts;
  } access_outcome_t;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      start    = 1'b0;
  logic                      op       = 1'b0;
  logic [DEF_ADDR_WIDTH-1:0] address  = '0;
  logic                      wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]      wr_index = REG_SET_BITS;
  logic [CFG_W-1:0]          wr_data  = '0;
  logic                      busy;
  logic                      done;
  logic                      hit;
  logic                      miss;
  logic                      eviction;
  logic                      modify_hit;
  logic [TOTAL_W-1:0]        hit_total;
  logic [TOTAL_W-1:0]        miss_total;
  logic [TOTAL_W-1:0]        eviction_total;

  request_t        request_q[$];
  access_outcome_t outcome_q[$];
  int              error_count = 0;
  int              results_seen = 0;
  int              settle_left = 0;

  // shadow tag store and configuration
  logic                      line_ok  [NUM_LINES];
  logic [DEF_ADDR_WIDTH-1:0] line_key [NUM_LINES];
  logic [STAMP_W-1:0]        line_age [NUM_LINES];
  logic [STAMP_W-1:0]        tick;
  logic [TOTAL_W-1:0]        hit_sum;
  logic [TOTAL_W-1:0]        miss_sum;
  logic [TOTAL_W-1:0]        evict_sum;
  logic [2:0]                m_set_bits;
  logic [3:0]                m_ways;
  logic [3:0]                m_block_bits;

  set_assoc_lru_cache_tags_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .address        (address),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .done           (done),
    .hit            (hit),
    .miss           (miss),
    .eviction       (eviction),
    .modify_hit     (modify_hit),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MAX_ERR_LINES) $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic int eff_set_bits(logic [2:0] sb);
    return (sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(sb);
  endfunction

  function automatic int eff_ways(logic [3:0] nw);
    if (nw == 0) return 1;
    return (nw > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(nw);
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < NUM_LINES; i++) line_ok[i] = 1'b0;
    tick         = '0;
    hit_sum      = '0;
    miss_sum     = '0;
    evict_sum    = '0;
    m_set_bits   = RST_SET_BITS;
    m_ways       = RST_WAYS;
    m_block_bits = RST_BLOCK_BITS;
  endfunction

  function automatic void model_write(cfg_reg_t sel, logic [CFG_W-1:0] v);
    case (sel)
      REG_SET_BITS:   m_set_bits   = v[2:0];
      REG_WAYS:       m_ways       = v;
      REG_BLOCK_BITS: m_block_bits = v;
      default: ;
    endcase
  endfunction

  // look the address up in the shadow store, update it and queue the outcome
  function automatic void model_access(logic op_i, logic [DEF_ADDR_WIDTH-1:0] addr_i);
    int                        sb;
    int                        nw;
    int                        bb;
    int                        base;
    int                        victim;
    logic [DEF_ADDR_WIDTH-1:0] key;
    logic                      found;
    logic                      free;
    access_outcome_t           res;
    sb     = eff_set_bits(m_set_bits);
    nw     = eff_ways(m_ways);
    bb     = int'(m_block_bits);
    base   = int'((addr_i >> bb) & ((64'd1 << sb) - 64'd1)) * DEF_MAX_WAYS;
    key    = addr_i >> (bb + sb);
    tick   = tick + 1'b1;
    found  = 1'b0;
    free   = 1'b0;
    victim = 0;
    for (int w = 0; w < nw; w++) begin
      if (!found && line_ok[base + w] && line_key[base + w] == key) begin
        line_age[base + w] = tick;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int w = 0; w < nw; w++) begin
        if (!free && !line_ok[base + w]) begin
          victim = w;
          free   = 1'b1;
        end
      end
      // full set: oldest stamp goes, lowest way on a tie
      if (!free) begin
        for (int w = 1; w < nw; w++) begin
          if (line_age[base + w] < line_age[base + victim]) victim = w;
        end
      end
      line_ok[base + victim]  = 1'b1;
      line_age[base + victim] = tick;
      line_key[base + victim] = key;
    end
    hit_sum        = hit_sum + TOTAL_W'(found) + TOTAL_W'(op_i);
    miss_sum       = miss_sum + TOTAL_W'(!found);
    evict_sum      = evict_sum + TOTAL_W'(!found && !free);
    res.hit        = found;
    res.miss       = !found;
    res.eviction   = !found && !free;
    res.modify_hit = op_i;
    res.hits       = hit_sum;
    res.misses     = miss_sum;
    res.evicts     = evict_sum;
    outcome_q.push_back(res);
  endfunction

  function automatic void push_access(logic op_i, logic [DEF_ADDR_WIDTH-1:0] a, int idle);
    request_t r;
    r          = '0;
    r.kind     = RQ_ACCESS;
    r.op       = op_i;
    r.addr     = a;
    r.idle_pct = idle;
    request_q.push_back(r);
  endfunction

  // wait for the block to drain, then write all three registers
  function automatic void push_config(logic [CFG_W-1:0] sb, logic [CFG_W-1:0] nw,
                                      logic [CFG_W-1:0] bb);
    request_t r;
    r      = '0;
    r.kind = RQ_SETTLE;
    request_q.push_back(r);
    r.kind    = RQ_WRITE;
    r.reg_sel = REG_SET_BITS;
    r.value   = sb;
    request_q.push_back(r);
    r.reg_sel = REG_WAYS;
    r.value   = nw;
    request_q.push_back(r);
    r.reg_sel = REG_BLOCK_BITS;
    r.value   = bb;
    request_q.push_back(r);
  endfunction

  // mostly reuse a few sets and small tags so hits and evictions are frequent
  function automatic void push_phase(logic [2:0] sb_w, logic [3:0] nw_w, logic [3:0] bb_w,
                                     int idle);
    int                        sb;
    int                        nw;
    int                        bb;
    int                        pick;
    int                        hot_set [4];
    logic [DEF_ADDR_WIDTH-1:0] far_key [4];
    logic [DEF_ADDR_WIDTH-1:0] key;
    logic [DEF_ADDR_WIDTH-1:0] set_part;
    logic [DEF_ADDR_WIDTH-1:0] a;
    sb = eff_set_bits(sb_w);
    nw = eff_ways(nw_w);
    bb = int'(bb_w);
    push_config({1'($urandom_range(0, 1)), sb_w}, nw_w, bb_w);
    for (int j = 0; j < 4; j++) begin
      hot_set[j] = $urandom_range(0, (1 << sb) - 1);
      far_key[j] = {$urandom, $urandom};
    end
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        a = {$urandom, $urandom};
      end else begin
        if (pick < 25) key = far_key[$urandom_range(0, 3)];
        else key = DEF_ADDR_WIDTH'($urandom_range(0, nw + 1));
        set_part = DEF_ADDR_WIDTH'(hot_set[$urandom_range(0, 3)]);
        a = (key << (bb + sb)) | (set_part << bb) |
            ({$urandom, $urandom} & ((64'd1 << bb) - 64'd1));
      end
      push_access(1'($urandom_range(0, 1)), a, idle);
    end
  endfunction

  always @(posedge clk) begin
    request_t                  head;
    logic                      raise;
    logic                      write;
    logic                      nxt_op;
    logic [DEF_ADDR_WIDTH-1:0] nxt_addr;
    logic [CFG_IDX_W-1:0]      nxt_idx;
    logic [CFG_W-1:0]          nxt_data;
    if (rst) begin
      model_reset();
      settle_left = 0;
      start <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      raise    = 1'b0;
      write    = 1'b0;
      nxt_op   = op;
      nxt_addr = address;
      nxt_idx  = wr_index;
      nxt_data = wr_data;
      if (start && !busy) begin
        model_access(op, address);
        void'(request_q.pop_front());
      end else if (start) begin
        raise = 1'b1;
      end
      if (!raise) begin
        if (settle_left > 0) begin
          settle_left--;
        end else if (request_q.size() > 0) begin
          head = request_q[0];
          case (head.kind)
            RQ_ACCESS: begin
              if ($urandom_range(0, 99) >= head.idle_pct) begin
                raise    = 1'b1;
                nxt_op   = head.op;
                nxt_addr = head.addr;
              end
            end
            RQ_WRITE: begin
              write    = 1'b1;
              nxt_idx  = head.reg_sel;
              nxt_data = head.value;
              model_write(head.reg_sel, head.value);
              void'(request_q.pop_front());
            end
            RQ_SETTLE: begin
              if (outcome_q.size() == 0) begin
                settle_left = SETTLE_CYCLES;
                void'(request_q.pop_front());
              end
            end
            default: ;
          endcase
        end
      end
      start    <= raise;
      wr_en    <= write;
      op       <= nxt_op;
      address  <= nxt_addr;
      wr_index <= nxt_idx;
      wr_data  <= nxt_data;
    end
  end

  always @(posedge clk) begin
    access_outcome_t want;
    if (!rst && done) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        flag_error($sformatf("result %0d with no request outstanding", results_seen));
      end else begin
        want = outcome_q.pop_front();
        if (hit !== want.hit)
          flag_error($sformatf("result %0d hit %b, want %b", results_seen, hit, want.hit));
        if (miss !== want.miss)
          flag_error($sformatf("result %0d miss %b, want %b", results_seen, miss, want.miss));
        if (eviction !== want.eviction)
          flag_error($sformatf("result %0d eviction %b, want %b", results_seen, eviction,
                               want.eviction));
        if (modify_hit !== want.modify_hit)
          flag_error($sformatf("result %0d modify_hit %b, want %b", results_seen, modify_hit,
                               want.modify_hit));
        if (hit_total !== want.hits)
          flag_error($sformatf("result %0d hit_total %0d, want %0d", results_seen, hit_total,
                               want.hits));
        if (miss_total !== want.misses)
          flag_error($sformatf("result %0d miss_total %0d, want %0d", results_seen,
                               miss_total, want.misses));
        if (eviction_total !== want.evicts)
          flag_error($sformatf("result %0d eviction_total %0d, want %0d", results_seen,
                               eviction_total, want.evicts));
      end
    end
  end

  initial begin
    // two ways, two sets, byte blocks: fill, modify hit, fill, LRU evictions
    push_config(4'd1, 4'd2, 4'd0);
    push_access(OP_ACCESS, 64'h0, 30);
    push_access(OP_MODIFY, 64'h0, 30);
    push_access(OP_ACCESS, 64'h2, 30);
    push_access(OP_ACCESS, 64'h4, 30);
    push_access(OP_ACCESS, 64'h0, 30);
    push_access(OP_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 30);
    push_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 30);
    push_access(OP_ACCESS, 64'h8000_0000_0000_0001, 30);
    // oversized set and way counts saturate, largest block size
    push_config(4'hF, 4'hF, 4'hF);
    push_access(OP_ACCESS, 64'h0, 30);
    push_access(OP_ACCESS, 64'h0000_0000_001F_8000, 30);
    push_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 30);
    push_access(OP_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 30);
    push_access(OP_ACCESS, 64'h0000_0000_0000_7FFF, 30);
    // zero ways acts as one; old lines stay valid under the new split
    push_config(4'd0, 4'd0, 4'd12);
    push_access(OP_ACCESS, 64'h0, 30);
    push_access(OP_ACCESS, 64'h1000, 30);
    push_access(OP_MODIFY, 64'h1FFF, 30);
    push_access(OP_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 30);

    for (int k = 0; k < NUM_PHASES; k++) begin
      case (k)
        0: push_phase(3'd0, 4'd1, 4'd0, 30);
        1: push_phase(3'd7, 4'd15, 4'd15, 30);
        2: push_phase(3'd6, 4'd8, 4'd12, 30);
        3: push_phase(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 0);
        default: push_phase(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)), 30);
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    while (request_q.size() > 0 || outcome_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
